>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on posedge with async reset off.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/sgsl_pkg.sv
// ----------------------------------------------------------------------------
// sgsl_pkg
// Types, widths and codes shared by the scatter-gather segment list modules.
// ----------------------------------------------------------------------------
package sgsl_pkg;

    // List depth and derived widths
    localparam int MAX_SEGMENTS = 16;
    localparam int CountW       = $clog2(MAX_SEGMENTS + 1);
    localparam int AddrW        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int WalkW        = (CountW + 1 > 7) ? CountW + 1 : 7;

    // Fixed field widths
    localparam int BaseW  = 32;
    localparam int LenW   = 16;
    localparam int NextW  = 6;
    localparam int SumW   = 21;
    localparam int IndexW = 7;
    localparam int EntryW = BaseW + 2 * LenW;

    typedef enum logic [1:0] {
        OP_APPEND    = 2'd0,
        OP_CLEAR     = 2'd1,
        OP_GET_SEG   = 2'd2,
        OP_GET_TOTAL = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_END  = 2'd2
    } status_t;

    // One stored list entry
    typedef struct packed {
        logic [BaseW-1:0] base;
        logic [LenW-1:0]  head;
        logic [LenW-1:0]  foot;
    } entry_t;

    // One result item
    typedef struct packed {
        status_t          status;
        logic [BaseW-1:0] seg_addr;
        logic [LenW-1:0]  seg_length;
        logic [NextW-1:0] next_index;
        logic [SumW-1:0]  total_length;
    } result_t;

endpackage

>>> src/sgsl_mem.sv
// ----------------------------------------------------------------------------
// sgsl_mem
// Entry RAM: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sgsl_mem (
    input  logic                      clk,
    input  logic                      we,
    input  logic [sgsl_pkg::AddrW-1:0] waddr,
    input  sgsl_pkg::entry_t          wdata,
    input  logic                      re,
    input  logic [sgsl_pkg::AddrW-1:0] raddr,
    output sgsl_pkg::entry_t          rdata
);

    sgsl_pkg::entry_t mem [sgsl_pkg::MAX_SEGMENTS];
    sgsl_pkg::entry_t rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data registered when re is high
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/sgsl_ctrl.sv
// ----------------------------------------------------------------------------
// sgsl_ctrl
// Operation sequencer: decodes an item, reads/writes the entry RAM, scans
// footers one entry per cycle and stages the result.
// ----------------------------------------------------------------------------
module sgsl_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    // item in
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  operation,
    input  logic [sgsl_pkg::LenW-1:0]   header_len,
    input  logic [sgsl_pkg::LenW-1:0]   footer_len,
    input  logic [sgsl_pkg::BaseW-1:0]  base_addr,
    input  logic [sgsl_pkg::IndexW-1:0] seg_index,
    // result out
    output logic                        res_valid,
    input  logic                        res_ready,
    output sgsl_pkg::result_t           res,
    // entry RAM
    output logic                        mem_we,
    output logic [sgsl_pkg::AddrW-1:0]  mem_waddr,
    output sgsl_pkg::entry_t            mem_wdata,
    output logic                        mem_re,
    output logic [sgsl_pkg::AddrW-1:0]  mem_raddr,
    input  sgsl_pkg::entry_t            mem_rdata
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_HEAD = 5'b00100,
        S_FOOT = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t                        state_reg, state_next;
    logic [sgsl_pkg::CountW-1:0]   count_reg, count_next;
    logic [sgsl_pkg::SumW-1:0]     sum_reg, sum_next;
    logic [sgsl_pkg::CountW-1:0]   k_reg, k_next;
    logic [sgsl_pkg::WalkW-1:0]    idx_reg, idx_next;
    sgsl_pkg::result_t             res_reg, res_next;

    // captured item
    sgsl_pkg::op_t                 op_reg;
    logic [sgsl_pkg::LenW-1:0]     hl_reg;
    logic [sgsl_pkg::LenW-1:0]     fl_reg;
    logic [sgsl_pkg::BaseW-1:0]    base_reg;
    logic [sgsl_pkg::IndexW-1:0]   raw_reg;

    // walk decode
    logic                          raw_is_m1;
    logic                          neg;
    logic [sgsl_pkg::WalkW-1:0]    idx_w;
    logic [sgsl_pkg::WalkW-1:0]    cnt_w;
    logic [sgsl_pkg::WalkW-1:0]    n2_w;
    logic [sgsl_pkg::WalkW-1:0]    head_e;
    logic [sgsl_pkg::WalkW-1:0]    foot_k;
    logic [sgsl_pkg::CountW-1:0]   k_inc;
    logic [sgsl_pkg::WalkW-1:0]    foot_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    assign raw_is_m1 = (raw_reg == {sgsl_pkg::IndexW{1'b1}});
    assign neg       = raw_reg[sgsl_pkg::IndexW-1] && !raw_is_m1;
    assign idx_w     = raw_is_m1 ? '0
                     : sgsl_pkg::WalkW'(raw_reg[sgsl_pkg::IndexW-2:0]);
    assign cnt_w     = sgsl_pkg::WalkW'(count_reg);
    assign n2_w      = sgsl_pkg::WalkW'({count_reg, 1'b0});
    assign head_e    = cnt_w - idx_w - sgsl_pkg::WalkW'(1);
    assign foot_k    = idx_w - cnt_w;
    assign k_inc     = k_reg + sgsl_pkg::CountW'(1);
    assign foot_next = sgsl_pkg::WalkW'(k_inc) + cnt_w;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        k_next     = k_reg;
        idx_next   = idx_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = count_reg[sgsl_pkg::AddrW-1:0];
        mem_wdata  = '{base: base_reg, head: hl_reg, foot: fl_reg};
        mem_re     = 1'b0;
        mem_raddr  = k_reg[sgsl_pkg::AddrW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_next            = '0;
                res_next.status     = sgsl_pkg::ST_OK;
                res_next.total_length = sum_reg;
                state_next          = S_DONE;
                case (op_reg)
                    sgsl_pkg::OP_APPEND:
                    begin
                        if (count_reg >= sgsl_pkg::CountW'(sgsl_pkg::MAX_SEGMENTS))
                        begin
                            res_next.status = sgsl_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + sgsl_pkg::CountW'(1);
                            sum_next   = sum_reg + sgsl_pkg::SumW'(hl_reg)
                                       + sgsl_pkg::SumW'(fl_reg);
                            res_next.total_length = sum_next;
                        end
                    end

                    sgsl_pkg::OP_CLEAR:
                    begin
                        count_next            = '0;
                        sum_next              = '0;
                        res_next.total_length = '0;
                    end

                    sgsl_pkg::OP_GET_SEG:
                    begin
                        idx_next = idx_w;
                        if (neg || idx_w >= n2_w)
                        begin
                            res_next.status = sgsl_pkg::ST_END;
                        end
                        else if (idx_w < cnt_w)
                        begin
                            // headers newest first
                            mem_re     = 1'b1;
                            mem_raddr  = head_e[sgsl_pkg::AddrW-1:0];
                            state_next = S_HEAD;
                        end
                        else
                        begin
                            // footers oldest first
                            mem_re     = 1'b1;
                            mem_raddr  = foot_k[sgsl_pkg::AddrW-1:0];
                            k_next     = foot_k[sgsl_pkg::CountW-1:0];
                            state_next = S_FOOT;
                        end
                    end

                    default:
                    begin
                        // total length only
                    end
                endcase
            end

            S_HEAD:
            begin
                res_next.seg_addr   = mem_rdata.base;
                res_next.seg_length = mem_rdata.head;
                res_next.next_index = sgsl_pkg::NextW'(idx_reg + sgsl_pkg::WalkW'(1));
                state_next          = S_DONE;
            end

            S_FOOT:
            begin
                if (mem_rdata.foot != '0)
                begin
                    res_next.seg_addr   = mem_rdata.base + sgsl_pkg::BaseW'(mem_rdata.head);
                    res_next.seg_length = mem_rdata.foot;
                    res_next.next_index = sgsl_pkg::NextW'(foot_next);
                    state_next          = S_DONE;
                end
                else if (k_inc >= count_reg)
                begin
                    res_next.status = sgsl_pkg::ST_END;
                    state_next      = S_DONE;
                end
                else
                begin
                    // skip empty footer, read the next entry
                    mem_re    = 1'b1;
                    mem_raddr = k_inc[sgsl_pkg::AddrW-1:0];
                    k_next    = k_inc;
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
        if (in_valid && in_ready)
        begin
            op_reg   <= sgsl_pkg::op_t'(operation);
            hl_reg   <= header_len;
            fl_reg   <= footer_len;
            base_reg <= base_addr;
            raw_reg  <= seg_index;
        end
    end

endmodule

>>> src/scatter_gather_segment_list.sv
// ----------------------------------------------------------------------------
// scatter_gather_segment_list
// Segment list for gather DMA: append, clear, total length and segment walk.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | fields
//  --------+-----------+---------------------+-----------------------------------
//  in      | to block  | in_valid / in_stall | operation, header_len, footer_len,
//          |           |                     | base_addr, seg_index
//  out     | from block| out_valid/out_stall | status, seg_addr, seg_length,
//          |           |                     | next_index, total_length
//
//  Append, clear and get total go through S_EXEC and S_DONE before the next accept.
//  A header segment adds S_HEAD; a footer segment adds S_FOOT, which stays while it
//  skips empty footers, the entry RAM read port scanning one entry a cycle.
//  Reset clears the entry count and total; the entry RAM is not cleared.
//  The output register holds a result while out_stall is high; the next item is
//  still accepted, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module scatter_gather_segment_list (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        operation,
    input  logic [sgsl_pkg::LenW-1:0]         header_len,
    input  logic [sgsl_pkg::LenW-1:0]         footer_len,
    input  logic [sgsl_pkg::BaseW-1:0]        base_addr,
    input  logic signed [sgsl_pkg::IndexW-1:0] seg_index,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic [sgsl_pkg::BaseW-1:0]        seg_addr,
    output logic [sgsl_pkg::LenW-1:0]         seg_length,
    output logic [sgsl_pkg::NextW-1:0]        next_index,
    output logic [sgsl_pkg::SumW-1:0]         total_length
);

    logic                       in_ready;
    logic                       res_valid;
    logic                       res_ready;
    sgsl_pkg::result_t          res;
    logic                       mem_we;
    logic [sgsl_pkg::AddrW-1:0] mem_waddr;
    sgsl_pkg::entry_t           mem_wdata;
    logic                       mem_re;
    logic [sgsl_pkg::AddrW-1:0] mem_raddr;
    sgsl_pkg::entry_t           mem_rdata;
    logic                       out_valid_reg;
    sgsl_pkg::result_t          out_reg;

    sgsl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .header_len (header_len),
        .footer_len (footer_len),
        .base_addr  (base_addr),
        .seg_index  (seg_index),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    sgsl_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_stall  = !in_ready;
    assign res_ready = !out_valid_reg || !out_stall;

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign seg_addr     = out_reg.seg_addr;
    assign seg_length   = out_reg.seg_length;
    assign next_index   = out_reg.next_index;
    assign total_length = out_reg.total_length;

endmodule

>>> src/sgsl_chk.sv
// ----------------------------------------------------------------------------
// sgsl_chk
// Port-level checks for the segment list, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sgsl_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [1:0]                        status,
    input logic [sgsl_pkg::BaseW-1:0]        seg_addr,
    input logic [sgsl_pkg::LenW-1:0]         seg_length,
    input logic [sgsl_pkg::NextW-1:0]        next_index,
    input logic [sgsl_pkg::SumW-1:0]         total_length
);

    // one item in flight: an accepted item blocks the next cycle
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall,
                 "second item accepted while busy")

    // a result with a non-ok status (full or end) carries no segment
    `ASSERT_IMPL(a_nonok_zero, clk, rst_n, out_valid && status != sgsl_pkg::ST_OK,
                 seg_addr == '0 && seg_length == '0 && next_index == '0,
                 "segment fields set on non-ok status")

    // only defined status codes leave the block
    `ASSERT_IMPL(a_status_code, clk, rst_n, out_valid,
                 status == sgsl_pkg::ST_OK || status == sgsl_pkg::ST_FULL
                 || status == sgsl_pkg::ST_END,
                 "undefined status code")

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                 out_valid && $stable(status) && $stable(seg_addr)
                 && $stable(total_length),
                 "stalled result changed")

endmodule

bind scatter_gather_segment_list sgsl_chk u_sgsl_chk (.*);
